FILE: hw/rtl/mk32_pkg.sv
// ----------------------------------------------------------------------------
// mk32_pkg
// Shared types and constants of the Matern 3/2 kernel evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package mk32_pkg;

    localparam int MUL_W = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SUM_W = 37;
    localparam int RAD_W = 54;
    localparam int ROOT_W = 27;
    localparam int REM_W = 28;
    localparam int T_W = 35;
    localparam int P_W = 33;
    localparam int CFG_W = 24;
    localparam int IDX_W = 2;
    localparam int MODE_W = 2;
    localparam int DIVD_W = 32;
    localparam int DIVS_W = 4;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic [P_W-1:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [MUL_W-1:0] EXP_NEG_ONE_Q32 = 34'd1580030169;
    localparam logic [DIVS_W-1:0] SERIES_TERMS = 4'd12;
    localparam logic [18:0] EXP_CUTOFF = 19'd24;

    localparam logic [CFG_W-1:0] RST_OUTPUT_SCALE = 24'd65536;
    localparam logic [CFG_W-1:0] RST_DISTANCE_GAIN = 24'd113512;

    localparam logic [IDX_W-1:0] IDX_OUTPUT_SCALE = 2'd0;
    localparam logic [IDX_W-1:0] IDX_DISTANCE_GAIN = 2'd1;
    localparam logic [IDX_W-1:0] IDX_RESULT_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_VALUE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEN_GRAD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SCALE_GRAD = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ACC_MUL,
        S_ACC_ADD,
        S_SQRT,
        S_GAIN,
        S_TSCALE,
        S_HMUL,
        S_HDIV_GO,
        S_HDIV_WAIT,
        S_EMUL,
        S_ERND,
        S_POST,
        S_WMUL,
        S_WRND,
        S_AMUL,
        S_ARND,
        S_RMUL,
        S_RRND,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

FILE: hw/rtl/mk32_mul.sv
// ----------------------------------------------------------------------------
// mk32_mul
// Shared unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mk32_mul (
    input  wire logic                         i_clk,
    input  wire logic [mk32_pkg::MUL_W-1:0]   i_a,
    input  wire logic [mk32_pkg::MUL_W-1:0]   i_b,
    output logic      [mk32_pkg::PROD_W-1:0]  o_prod
);

    logic [mk32_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= mk32_pkg::PROD_W'(i_a) * mk32_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

FILE: hw/rtl/mk32_div.sv
// ----------------------------------------------------------------------------
// mk32_div
// Reciprocal table for the Horner divides by 1 to 12 and quotient select.
// The quotient of a 32-bit dividend is taken from the product of the dividend
// and the rounded-up reciprocal, shifted right by 32 plus ceil(log2 k).
// ----------------------------------------------------------------------------
`default_nettype none

module mk32_div (
    input  wire logic [mk32_pkg::DIVS_W-1:0]   i_divisor,
    input  wire logic [mk32_pkg::PROD_W-1:0]   i_prod,
    output logic      [mk32_pkg::MUL_W-1:0]    o_recip,
    output logic      [mk32_pkg::DIVD_W-1:0]   o_quot
);

    always_comb begin
        o_recip = '0;
        o_quot  = '0;
        unique case (i_divisor)
            4'd1: begin
                o_recip = 34'd4294967296;
                o_quot  = i_prod[63:32];
            end
            4'd2: begin
                o_recip = 34'd4294967296;
                o_quot  = i_prod[64:33];
            end
            4'd3: begin
                o_recip = 34'd5726623062;
                o_quot  = i_prod[65:34];
            end
            4'd4: begin
                o_recip = 34'd4294967296;
                o_quot  = i_prod[65:34];
            end
            4'd5: begin
                o_recip = 34'd6871947674;
                o_quot  = i_prod[66:35];
            end
            4'd6: begin
                o_recip = 34'd5726623062;
                o_quot  = i_prod[66:35];
            end
            4'd7: begin
                o_recip = 34'd4908534053;
                o_quot  = i_prod[66:35];
            end
            4'd8: begin
                o_recip = 34'd4294967296;
                o_quot  = i_prod[66:35];
            end
            4'd9: begin
                o_recip = 34'd7635497416;
                o_quot  = i_prod[67:36];
            end
            4'd10: begin
                o_recip = 34'd6871947674;
                o_quot  = i_prod[67:36];
            end
            4'd11: begin
                o_recip = 34'd6247225158;
                o_quot  = i_prod[67:36];
            end
            4'd12: begin
                o_recip = 34'd5726623062;
                o_quot  = i_prod[67:36];
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/matern32_kernel_eval_core.sv
// ----------------------------------------------------------------------------
// matern32_kernel_eval_core
// Fixed-point Matern 3/2 covariance and gradient evaluator.
// ----------------------------------------------------------------------------
// Each request carries one coordinate of two points; the request marked last
// closes the pair and yields one Q16.16 result. Requests are taken one at a
// time: a non-final coordinate is squared on the shared multiplier and added
// with saturation. The final one then runs a bit-serial square root giving a
// 27-bit root, the gain multiply, the exp(-frac) Horner series of 12 terms
// (each a multiply, a reciprocal multiply for the divide and a quotient
// pick), n multiplies by exp(-1) where n = floor(t) < 24, then the (1 + t)
// multiply, or two multiplies by t for the length-scale gradient, and the
// output-scale multiply; when t reaches 24 the series is skipped and the result is zero.
// The result sits in an output register, so the next request is taken while
// it waits; a later result waits until that register is free. All products
// go through one registered 34x34 multiplier.
`default_nettype none

module matern32_kernel_eval_core #(
    parameter int MAX_DIM = 16,
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic signed [COORD_WIDTH-1:0]  i_coord_first,
    input  wire logic signed [COORD_WIDTH-1:0]  i_coord_second,
    input  wire logic                           i_last_component,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic      [31:0]                    o_kernel_value,
    input  wire logic                           i_cfg_we,
    input  wire logic [mk32_pkg::IDX_W-1:0]     i_cfg_index,
    input  wire logic [mk32_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int MAG_W = COORD_WIDTH + 1;

    mk32_pkg::t_state r_state, n_state;

    logic [mk32_pkg::CFG_W-1:0]   r_sf2, r_gain;
    logic [mk32_pkg::MODE_W-1:0]  r_mode;
    logic [CNT_W-1:0]             r_count, n_count;
    logic [mk32_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic                         r_last, n_last;
    logic [mk32_pkg::MUL_W-1:0]   r_mag, n_mag;
    logic [mk32_pkg::RAD_W-1:0]   r_rad, n_rad;
    logic [mk32_pkg::REM_W-1:0]   r_rem, n_rem;
    logic [mk32_pkg::ROOT_W-1:0]  r_root, n_root;
    logic [4:0]                   r_iter, n_iter;
    logic [mk32_pkg::T_W-1:0]     r_t, n_t;
    logic [mk32_pkg::P_W-1:0]     r_p, n_p;
    logic [mk32_pkg::DIVS_W-1:0]  r_k, n_k;
    logic [4:0]                   r_n, n_n;
    logic [mk32_pkg::MUL_W-1:0]   r_a, n_a;
    logic [31:0]                  r_res, n_res;
    logic                         r_oval, n_oval;
    logic [31:0]                  r_kernel, n_kernel;

    logic [mk32_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic [mk32_pkg::PROD_W-1:0]  prod;
    logic [mk32_pkg::MUL_W-1:0]   div_recip;
    logic [mk32_pkg::DIVD_W-1:0]  div_quot;

    logic                         in_acc;
    logic signed [MAG_W-1:0]      diff;
    logic [MAG_W-1:0]             mag_raw;
    logic [64:0]                  sum_wide;
    logic [mk32_pkg::SUM_W-1:0]   sum_new;
    logic [29:0]                  rem_sh, trial, rem_sub;
    logic [51:0]                  t_wide;
    logic [mk32_pkg::PROD_W-1:0]  rnd16, rnd32;
    logic [36:0]                  r_dbl;

    mk32_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    mk32_div u_div (
        .i_divisor (r_k),
        .i_prod    (prod),
        .o_recip   (div_recip),
        .o_quot    (div_quot)
    );

    assign in_acc  = i_in_valid && !o_in_stall;
    assign diff    = MAG_W'(i_coord_first) - MAG_W'(i_coord_second);
    assign mag_raw = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);

    assign sum_wide = 65'(r_sum) + 65'(prod[63:0]);
    assign sum_new  = (r_mag[33:32] != 2'b00 || sum_wide > 65'(mk32_pkg::SUM_MAX))
                      ? mk32_pkg::SUM_MAX : sum_wide[mk32_pkg::SUM_W-1:0];

    assign rem_sh  = {r_rem, r_rad[mk32_pkg::RAD_W-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign rem_sub = rem_sh - trial;

    assign t_wide = 52'(prod[50:0]) + 52'h8000;
    assign rnd16  = prod + mk32_pkg::PROD_W'(32'h8000);
    assign rnd32  = prod + mk32_pkg::PROD_W'(32'h8000_0000);
    assign r_dbl  = (r_mode == mk32_pkg::MODE_SCALE_GRAD) ? {rnd32[67:32], 1'b0}
                                                          : {1'b0, rnd32[67:32]};

    assign o_in_stall     = r_state != mk32_pkg::S_IDLE;
    assign o_out_valid    = r_oval;
    assign o_kernel_value = r_kernel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sf2  <= mk32_pkg::RST_OUTPUT_SCALE;
            r_gain <= mk32_pkg::RST_DISTANCE_GAIN;
            r_mode <= mk32_pkg::MODE_VALUE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mk32_pkg::IDX_OUTPUT_SCALE:  r_sf2  <= i_cfg_data;
                mk32_pkg::IDX_DISTANCE_GAIN: r_gain <= i_cfg_data;
                mk32_pkg::IDX_RESULT_MODE:   r_mode <= i_cfg_data[mk32_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mk32_pkg::S_IDLE;
            r_count <= '0;
            r_sum   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_sum   <= n_sum;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last   <= n_last;
        r_mag    <= n_mag;
        r_rad    <= n_rad;
        r_rem    <= n_rem;
        r_root   <= n_root;
        r_iter   <= n_iter;
        r_t      <= n_t;
        r_p      <= n_p;
        r_k      <= n_k;
        r_n      <= n_n;
        r_a      <= n_a;
        r_res    <= n_res;
        r_kernel <= n_kernel;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_sum    = r_sum;
        n_last   = r_last;
        n_mag    = r_mag;
        n_rad    = r_rad;
        n_rem    = r_rem;
        n_root   = r_root;
        n_iter   = r_iter;
        n_t      = r_t;
        n_p      = r_p;
        n_k      = r_k;
        n_n      = r_n;
        n_a      = r_a;
        n_res    = r_res;
        n_oval   = r_oval && i_out_stall;
        n_kernel = r_kernel;
        mul_a    = r_mag;
        mul_b    = r_mag;

        unique case (r_state)
            mk32_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_last = i_last_component;
                    n_mag  = mk32_pkg::MUL_W'(mag_raw);
                    if (r_count < CNT_W'(MAX_DIM)) begin
                        n_count = r_count + CNT_W'(1);
                        n_state = mk32_pkg::S_ACC_MUL;
                    end else if (i_last_component) begin
                        n_rad   = {1'b0, r_sum, 16'h0};
                        n_sum   = '0;
                        n_count = '0;
                        n_rem   = '0;
                        n_root  = '0;
                        n_iter  = '0;
                        n_state = mk32_pkg::S_SQRT;
                    end
                end
            end
            mk32_pkg::S_ACC_MUL: begin
                n_state = mk32_pkg::S_ACC_ADD;
            end
            mk32_pkg::S_ACC_ADD: begin
                if (r_last) begin
                    n_rad   = {1'b0, sum_new, 16'h0};
                    n_sum   = '0;
                    n_count = '0;
                    n_rem   = '0;
                    n_root  = '0;
                    n_iter  = '0;
                    n_state = mk32_pkg::S_SQRT;
                end else begin
                    n_sum   = sum_new;
                    n_state = mk32_pkg::S_IDLE;
                end
            end
            mk32_pkg::S_SQRT: begin
                n_rad  = {r_rad[mk32_pkg::RAD_W-3:0], 2'b00};
                n_iter = r_iter + 5'd1;
                if (rem_sh >= trial) begin
                    n_rem  = rem_sub[mk32_pkg::REM_W-1:0];
                    n_root = {r_root[mk32_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh[mk32_pkg::REM_W-1:0];
                    n_root = {r_root[mk32_pkg::ROOT_W-2:0], 1'b0};
                end
                if (r_iter == 5'(mk32_pkg::ROOT_W - 1)) begin
                    n_state = mk32_pkg::S_GAIN;
                end
            end
            mk32_pkg::S_GAIN: begin
                mul_a   = mk32_pkg::MUL_W'(r_root);
                mul_b   = mk32_pkg::MUL_W'(r_gain);
                n_state = mk32_pkg::S_TSCALE;
            end
            mk32_pkg::S_TSCALE: begin
                n_t = t_wide[50:16];
                n_p = mk32_pkg::ONE_Q32;
                n_k = mk32_pkg::SERIES_TERMS;
                n_n = t_wide[36:32];
                if (t_wide[50:32] >= mk32_pkg::EXP_CUTOFF) begin
                    n_res   = '0;
                    n_state = mk32_pkg::S_OUT;
                end else begin
                    n_state = mk32_pkg::S_HMUL;
                end
            end
            mk32_pkg::S_HMUL: begin
                mul_a   = mk32_pkg::MUL_W'(r_t[15:0]);
                mul_b   = mk32_pkg::MUL_W'(r_p);
                n_state = mk32_pkg::S_HDIV_GO;
            end
            mk32_pkg::S_HDIV_GO: begin
                mul_a   = mk32_pkg::MUL_W'(prod[47:16]);
                mul_b   = div_recip;
                n_state = mk32_pkg::S_HDIV_WAIT;
            end
            mk32_pkg::S_HDIV_WAIT: begin
                n_p = mk32_pkg::ONE_Q32 - mk32_pkg::P_W'(div_quot);
                n_k = r_k - 4'd1;
                if (r_k != 4'd1) begin
                    n_state = mk32_pkg::S_HMUL;
                end else if (r_n != 5'd0) begin
                    n_state = mk32_pkg::S_EMUL;
                end else begin
                    n_state = mk32_pkg::S_POST;
                end
            end
            mk32_pkg::S_EMUL: begin
                mul_a   = mk32_pkg::MUL_W'(r_p);
                mul_b   = mk32_pkg::EXP_NEG_ONE_Q32;
                n_state = mk32_pkg::S_ERND;
            end
            mk32_pkg::S_ERND: begin
                n_p = rnd32[64:32];
                n_n = r_n - 5'd1;
                n_state = (r_n == 5'd1) ? mk32_pkg::S_POST : mk32_pkg::S_EMUL;
            end
            mk32_pkg::S_POST: begin
                if (r_p == '0) begin
                    n_res   = '0;
                    n_state = mk32_pkg::S_OUT;
                end else if (r_mode == mk32_pkg::MODE_LEN_GRAD) begin
                    n_state = mk32_pkg::S_WMUL;
                end else begin
                    n_state = mk32_pkg::S_AMUL;
                end
            end
            mk32_pkg::S_WMUL: begin
                mul_a   = mk32_pkg::MUL_W'(r_t[20:0]);
                mul_b   = mk32_pkg::MUL_W'(r_p);
                n_state = mk32_pkg::S_WRND;
            end
            mk32_pkg::S_WRND: begin
                n_a     = rnd16[49:16];
                n_state = mk32_pkg::S_AMUL;
            end
            mk32_pkg::S_AMUL: begin
                if (r_mode == mk32_pkg::MODE_LEN_GRAD) begin
                    mul_a = r_a;
                    mul_b = mk32_pkg::MUL_W'(r_t[20:0]);
                end else begin
                    mul_a = mk32_pkg::MUL_W'(22'(r_t[20:0]) + 22'h10000);
                    mul_b = mk32_pkg::MUL_W'(r_p);
                end
                n_state = mk32_pkg::S_ARND;
            end
            mk32_pkg::S_ARND: begin
                n_a     = rnd16[49:16];
                n_state = mk32_pkg::S_RMUL;
            end
            mk32_pkg::S_RMUL: begin
                mul_a   = mk32_pkg::MUL_W'(r_sf2);
                mul_b   = r_a;
                n_state = mk32_pkg::S_RRND;
            end
            mk32_pkg::S_RRND: begin
                n_res   = (r_dbl[36:32] != 5'd0) ? 32'hFFFF_FFFF : r_dbl[31:0];
                n_state = mk32_pkg::S_OUT;
            end
            mk32_pkg::S_OUT: begin
                if (!r_oval || !i_out_stall) begin
                    n_kernel = r_res;
                    n_oval   = 1'b1;
                    n_state  = mk32_pkg::S_IDLE;
                end
            end
            default: n_state = mk32_pkg::S_IDLE;
        endcase
    end

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_kernel_value)))
        else $error("stalled result changed or dropped");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_DIM))
        else $error("component count beyond MAX_DIM");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mk32_pkg::S_OUT) |=> (r_sum == '0 && r_count == '0))
        else $error("sum not cleared after result");

endmodule

`default_nettype wire
